// File: sv/whf_pkg.sv
`timescale 1ns / 1ps
package whf_pkg;
    localparam int MaxPoints  = 16;
    localparam int PtrW       = 4;
    localparam int CoordW     = 16;
    localparam int CordicW    = 36;
    localparam int ZW         = 20;
    localparam int CordicSteps = 16;
    localparam int StepW      = 4;

    localparam logic signed [ZW-1:0] ZHalfPi = 20'sd102944;
    localparam logic signed [17:0] QPiWrap = 18'sd12861;
    localparam logic signed [17:0] QPiNear = 18'sd12868;
    localparam logic signed [17:0] QTwoPi  = 18'sd25723;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_LOAD  = 2'd1,
        MODE_ARM   = 2'd2,
        MODE_SAMPLE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CFG_COUNT  = 2'd0,
        CFG_REPEAT = 2'd1,
        CFG_SPEED  = 2'd2,
        CFG_DIST   = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_PREP,
        ST_RUN,
        ST_WRAP,
        ST_OUT
    } state_t;

    function automatic logic signed [ZW-1:0] atan_entry(input logic [StepW-1:0] i);
        logic signed [ZW-1:0] r;
        begin
            unique case (i)
                4'd0: r = 20'sd51472;
                4'd1: r = 20'sd30385;
                4'd2: r = 20'sd16055;
                4'd3: r = 20'sd8150;
                4'd4: r = 20'sd4091;
                4'd5: r = 20'sd2047;
                4'd6: r = 20'sd1024;
                4'd7: r = 20'sd512;
                4'd8: r = 20'sd256;
                4'd9: r = 20'sd128;
                4'd10: r = 20'sd64;
                4'd11: r = 20'sd32;
                4'd12: r = 20'sd16;
                4'd13: r = 20'sd8;
                4'd14: r = 20'sd4;
                default: r = 20'sd2;
            endcase
            return r;
        end
    endfunction
endpackage

// File: sv/waypoint_heading_follower_top.sv
`timescale 1ns / 1ps
// waypoint heading follower
// input channel: in_valid / in_stall carries mode, x_pos, y_pos, heading.
// output channel: out_valid / out_stall carries one result per input transfer.
// mode 0 clears the path state, mode 1 loads a waypoint, mode 2 arms,
// mode 3 is a position sample that yields speed and heading commands.
// clear/load/arm and samples while unarmed or finished go straight to the
// output state; a live sample passes table read, setup, the 16-step iterative
// cordic (one micro-rotation per cycle) and wrap before its result.
// one item is processed at a time; in_stall is high while busy.
// the result sits in an output register until taken; while out_stall is
// high the result holds and in_stall stays high, so the next input
// transfer waits until the result is taken.
// reset clears path state to empty, target 1, registers to their reset values;
// waypoint table contents stay undefined until loaded. configuration is written
// via cfg_we/cfg_addr/cfg_data; the user must do so only while idle, unchecked.
module waypoint_heading_follower_top
    import whf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_addr,
    input  logic [35:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         mode,
    input  logic signed [15:0] x_pos,
    input  logic signed [15:0] y_pos,
    input  logic signed [15:0] heading,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] speed_cmd,
    output logic signed [16:0] angle_cmd,
    output logic               driving,
    output logic               reached,
    output logic               finished,
    output logic               table_full,
    output logic [3:0]         target_index
);
    logic [4:0] count_reg;
    logic repeat_reg;
    logic signed [15:0] speed_reg;
    logic [35:0] dist_thr_reg;

    logic signed [CoordW-1:0] wx_mem [MaxPoints];
    logic signed [CoordW-1:0] wy_mem [MaxPoints];
    logic signed [CoordW-1:0] wx_rd_reg, wy_rd_reg;

    logic [4:0] load_reg;
    logic [PtrW-1:0] ptr_reg;
    logic full_reg, armed_reg, done_reg;

    state_t state_reg, state_next;
    logic signed [CoordW-1:0] px_reg, py_reg;
    logic signed [15:0] alpha_reg;
    logic signed [CoordW:0] dx_reg, dy_reg;
    logic [34:0] dist_reg;

    logic out_valid_reg;
    logic signed [15:0] spd_o_reg;
    logic signed [16:0] ang_o_reg;
    logic drv_o_reg, rch_o_reg;

    logic in_xfer, cordic_start, cordic_busy;
    logic signed [ZW-1:0] z_out;
    logic [4:0] cnt;
    logic signed [CoordW:0] dx_c, dy_c;
    logic [CoordW:0] adx, ady;
    logic [33:0] sq_x, sq_y;
    logic signed [17:0] a0, a1, a2, a3;
    logic signed [ZW-1:0] zr;

    assign in_stall = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign in_xfer = in_valid && !in_stall;

    // clamp of the path length to 2..16
    assign cnt = (count_reg < 5'd2) ? 5'd2 :
                 (count_reg > 5'(MaxPoints)) ? 5'(MaxPoints) : count_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 5'd16;
            repeat_reg <= 1'b0;
            speed_reg <= '0;
            dist_thr_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_COUNT:  count_reg <= cfg_data[4:0];
                CFG_REPEAT: repeat_reg <= cfg_data[0];
                CFG_SPEED:  speed_reg <= cfg_data[15:0];
                CFG_DIST:   dist_thr_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // waypoint table
    always_ff @(posedge clk)
    begin
        if (in_xfer && mode_t'(mode) == MODE_LOAD && load_reg < cnt)
        begin
            wx_mem[load_reg[PtrW-1:0]] <= x_pos;
            wy_mem[load_reg[PtrW-1:0]] <= y_pos;
        end
        wx_rd_reg <= wx_mem[ptr_reg];
        wy_rd_reg <= wy_mem[ptr_reg];
    end

    whf_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .dx    (dx_reg),
        .dy    (dy_reg),
        .busy  (cordic_busy),
        .z_out (z_out)
    );

    always_comb
    begin
        dx_c = CoordW'(0) + (CoordW+1)'(wx_rd_reg) - (CoordW+1)'(px_reg);
        dy_c = (CoordW+1)'(wy_rd_reg) - (CoordW+1)'(py_reg);
        adx = dx_reg[CoordW] ? (CoordW+1)'(-dx_reg) : dx_reg;
        ady = dy_reg[CoordW] ? (CoordW+1)'(-dy_reg) : dy_reg;
        sq_x = adx * adx;
        sq_y = ady * ady;
        zr = (z_out + ZW'(8)) >>> 4;
        a0 = (dx_reg == 0 && dy_reg == 0) ? 18'sd0 : 18'(zr);
        a1 = a0;
        if (a0 > QPiWrap) a1 = a0 - QTwoPi;
        a2 = a1;
        if (a1 < -QPiWrap) a2 = a1 + QTwoPi;
        a3 = a2;
        if (18'(alpha_reg) - a2 > QPiNear) a3 = a2 + QTwoPi;
        else if (a2 - 18'(alpha_reg) > QPiNear) a3 = a2 - QTwoPi;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cordic_start = 1'b0;
        unique case (state_reg)
            ST_IDLE:
                if (in_xfer)
                begin
                    if (mode_t'(mode) == MODE_SAMPLE && armed_reg && !done_reg)
                        state_next = ST_READ;
                    else
                        state_next = ST_OUT;
                end
            ST_READ: state_next = ST_PREP;
            ST_PREP:
            begin
                cordic_start = 1'b1;
                state_next = ST_RUN;
            end
            ST_RUN:
                if (!cordic_busy)
                    state_next = ST_WRAP;
            ST_WRAP: state_next = ST_OUT;
            ST_OUT:
                if (!(out_valid_reg && out_stall))
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // path state, datapath and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            load_reg <= '0;
            ptr_reg <= PtrW'(1);
            full_reg <= 1'b0;
            armed_reg <= 1'b0;
            done_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            drv_o_reg <= 1'b0;
            rch_o_reg <= 1'b0;
            spd_o_reg <= '0;
            ang_o_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                    if (in_xfer)
                    begin
                        drv_o_reg <= 1'b0;
                        rch_o_reg <= 1'b0;
                        spd_o_reg <= '0;
                        ang_o_reg <= '0;
                        unique case (mode_t'(mode))
                            MODE_CLEAR:
                            begin
                                load_reg <= '0;
                                ptr_reg <= PtrW'(1);
                                full_reg <= 1'b0;
                                armed_reg <= 1'b0;
                                done_reg <= 1'b0;
                            end
                            MODE_LOAD:
                            begin
                                if (load_reg < cnt)
                                begin
                                    load_reg <= load_reg + 5'd1;
                                    full_reg <= (load_reg + 5'd1 >= cnt);
                                end
                                else
                                    full_reg <= 1'b1;
                            end
                            MODE_ARM: armed_reg <= full_reg;
                            default: ;
                        endcase
                    end
                ST_PREP: ;
                ST_WRAP:
                begin
                    if ({29'd0, dist_reg} < {28'd0, dist_thr_reg})
                    begin
                        rch_o_reg <= 1'b1;
                        if ({1'b0, ptr_reg} + 5'd1 >= cnt)
                        begin
                            if (repeat_reg)
                                ptr_reg <= PtrW'(1);
                            else
                                done_reg <= 1'b1;
                        end
                        else
                            ptr_reg <= ptr_reg + 1'b1;
                    end
                    drv_o_reg <= 1'b1;
                    spd_o_reg <= speed_reg;
                    ang_o_reg <= 17'(a3);
                end
                ST_OUT:
                    if (!(out_valid_reg && out_stall))
                        out_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    // sample operands and distance
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            px_reg <= x_pos;
            py_reg <= y_pos;
            alpha_reg <= heading;
        end
        if (state_reg == ST_READ)
        begin
            dx_reg <= dx_c;
            dy_reg <= dy_c;
        end
        if (state_reg == ST_PREP)
            dist_reg <= 35'(sq_x) + 35'(sq_y);
    end

    assign out_valid    = out_valid_reg;
    assign speed_cmd    = spd_o_reg;
    assign angle_cmd    = ang_o_reg;
    assign driving      = drv_o_reg;
    assign reached      = rch_o_reg;
    assign finished     = done_reg;
    assign table_full   = full_reg;
    assign target_index = ptr_reg;
endmodule

// File: sv/whf_cordic.sv
`timescale 1ns / 1ps
module whf_cordic
    import whf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [CoordW:0]   dx,
    input  logic signed [CoordW:0]   dy,
    output logic                     busy,
    output logic signed [ZW-1:0]     z_out
);
    logic signed [CordicW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic [StepW-1:0] step_reg, step_next;
    logic busy_reg, busy_next;
    logic signed [CordicW-1:0] xe, ye, xs, ys;

    // one micro-rotation per cycle, shift by the step count
    always_comb
    begin
        xe = CordicW'(dx) <<< 12;
        ye = CordicW'(dy) <<< 12;
        xs = x_reg >>> step_reg;
        ys = y_reg >>> step_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            if (dx < 0 && dy >= 0)
            begin
                x_next = ye; y_next = -xe; z_next = ZHalfPi;
            end
            else if (dx < 0)
            begin
                x_next = -ye; y_next = xe; z_next = -ZHalfPi;
            end
            else
            begin
                x_next = xe; y_next = ye; z_next = '0;
            end
            if (dx == 0 && dy == 0)
            begin
                x_next = '0; y_next = '0;
            end
        end
        else if (busy_reg)
        begin
            if (y_reg > 0)
            begin
                x_next = x_reg + ys; y_next = y_reg - xs;
                z_next = z_reg + atan_entry(step_reg);
            end
            else
            begin
                x_next = x_reg - ys; y_next = y_reg + xs;
                z_next = z_reg - atan_entry(step_reg);
            end
            step_next = step_reg + 1'b1;
            if (step_reg == StepW'(CordicSteps - 1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign busy  = busy_reg;
    assign z_out = z_reg;
endmodule
